### design/wmr_pkg.sv
package wmr_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int LEN_W      = 5;
    localparam int WINDOW_DEF = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [SAMPLE_W-1:0] t_rise;
    typedef logic        [LEN_W-1:0]    t_len;

    localparam t_len LEN_RST = t_len'(1);

endpackage

### design/wmr_if.sv
interface wmr_in_if;
    import wmr_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;
    logic    last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface wmr_out_if;
    import wmr_pkg::*;

    logic  valid;
    logic  ready;
    t_rise best_rise;
    logic  final_res;

    modport source (output valid, output best_rise, output final_res, input ready);
    modport sink   (input valid, input best_rise, input final_res, output ready);
endinterface

### design/wmr_cell.sv
module wmr_cell (
    input  logic             i_clk,
    input  logic             i_en,
    input  wmr_pkg::t_sample i_sample,
    input  wmr_pkg::t_sample i_prev_min,
    output wmr_pkg::t_sample o_min
);
    import wmr_pkg::*;

    t_sample r_min;
    t_sample n_min;

    // running min of this cell's span: new sample against the neighbor's span
    always_comb begin
        n_min = (i_sample < i_prev_min) ? i_sample : i_prev_min;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_min <= n_min;
        end
    end

    assign o_min = r_min;

endmodule

### design/window_max_rise.sv
// Each result is registered in s1 and then in the out stage after request accept.
// Throughput: one request per cycle without output stalls; a chain of WINDOW
// min cells, each updated per accepted sample, holds the recent prefix minima.
// Reset (synchronous, active low): window length 1, empty window, best rise 0,
// pipeline empty. Cell contents are not cleared; the fill count gates them.
module window_max_rise #(
    parameter int WINDOW = wmr_pkg::WINDOW_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  wmr_pkg::t_len i_cfg_wdata,
    wmr_in_if.sink        i_in,
    wmr_out_if.source     o_out
);
    import wmr_pkg::*;

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    t_len              r_len;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] len_c;
    logic [FILL_W-1:0] span;
    logic [IDX_W-1:0]  sel;
    t_sample           cell_min [WINDOW];
    t_sample           win_min;
    logic [SAMPLE_W:0] diff;
    t_rise             n_rise;

    logic  r_s1_valid;
    t_rise r_s1_rise;
    logic  r_s1_last;
    logic  r_out_valid;
    t_rise r_out_best;
    logic  r_out_last;
    t_rise r_best;
    t_rise n_best;

    logic accept;
    logic s1_move;

    assign s1_move    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_move;
    assign accept     = i_in.valid && i_in.ready;

    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            if (g == 0) begin : g_head
                wmr_cell u_cell (
                    .i_clk      (i_clk),
                    .i_en       (accept),
                    .i_sample   (i_in.sample),
                    .i_prev_min (i_in.sample),
                    .o_min      (cell_min[g])
                );
            end else begin : g_body
                wmr_cell u_cell (
                    .i_clk      (i_clk),
                    .i_en       (accept),
                    .i_sample   (i_in.sample),
                    .i_prev_min (cell_min[g-1]),
                    .o_min      (cell_min[g])
                );
            end
        end
    endgenerate

    always_comb begin
        if (r_len == '0) begin
            len_c = FILL_W'(1);
        end else if (int'(r_len) > WINDOW) begin
            len_c = FILL_W'(WINDOW);
        end else begin
            len_c = FILL_W'(r_len);
        end
        span    = (r_fill < len_c) ? r_fill : len_c;
        sel     = IDX_W'(span - FILL_W'(1));
        win_min = cell_min[sel];
        diff    = {i_in.sample[SAMPLE_W-1], i_in.sample} - {win_min[SAMPLE_W-1], win_min};
        n_rise  = (span != '0 && !diff[SAMPLE_W]) ? diff[SAMPLE_W-1:0] : '0;

        if (i_in.last_sample) begin
            n_fill = '0;
        end else if (r_fill < FILL_W'(WINDOW)) begin
            n_fill = r_fill + FILL_W'(1);
        end else begin
            n_fill = r_fill;
        end

        n_best = (r_s1_rise > r_best) ? r_s1_rise : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_RST;
            r_fill      <= '0;
            r_best      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (accept) begin
                r_fill <= n_fill;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
                r_best      <= r_s1_last ? '0 : n_best;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rise <= n_rise;
            r_s1_last <= i_in.last_sample;
        end
        if (s1_move) begin
            r_out_best <= n_best;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.best_rise = r_out_best;
    assign o_out.final_res = r_out_last;

endmodule
